// ----- rtl/modexp_pkg.sv -----
// shared types and constants for the modular exponentiation block
`default_nettype none

package modexp_pkg;

    localparam int MODEXP_WIDTH = 32;
    localparam int FIELD_W      = 32;
    localparam logic [FIELD_W-1:0] MOD_RESET = 32'd2;

    // what the shared multiplier is working on, also selects the write-back
    typedef enum logic [1:0] {
        OP_REDUCE = 2'd0,
        OP_MUL    = 2'd1,
        OP_SQR    = 2'd2
    } t_op;

    typedef struct packed {
        logic load;
        logic start;
        t_op  op;
        logic shift_exp;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic mul_done;
        logic exp_bit0;
        logic exp_zero;
        logic mod_small;
    } t_dp_stat;

endpackage

`default_nettype wire

// ----- rtl/modexp_mulmod.sv -----
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`default_nettype none

module modexp_mulmod #(
    parameter int WIDTH = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire [WIDTH-1:0]  i_a,
    input  wire [WIDTH-1:0]  i_b,
    input  wire [WIDTH-1:0]  i_m,
    output logic [WIDTH-1:0] o_result,
    output logic             o_done
);
    localparam int CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic [WIDTH-1:0] r_r;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [WIDTH:0] t1;
    logic [WIDTH:0] t1r;
    logic [WIDTH:0] t2;
    logic [WIDTH:0] t2r;
    logic [WIDTH:0] m_ext;

    // r stays below m as long as b is below m, or b is one
    always_comb begin
        m_ext = {1'b0, i_m};
        t1    = {r_r, 1'b0};
        t1r   = (t1 >= m_ext) ? (t1 - m_ext) : t1;
        t2    = t1r + (r_a[WIDTH-1] ? {1'b0, r_b} : '0);
        t2r   = (t2 >= m_ext) ? (t2 - m_ext) : t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r   <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
            r_cnt <= CNT_W'(WIDTH - 1);
        end else if (r_busy) begin
            r_r   <= t2r[WIDTH-1:0];
            r_a   <= {r_a[WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_result = r_r;
    assign o_done   = r_done;

endmodule

`default_nettype wire

// ----- rtl/modexp_dp.sv -----
// datapath: modulus register, result and square registers, exponent shifter
`default_nettype none

module modexp_dp #(
    parameter int WIDTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                i_cfg_we,
    input  wire [modexp_pkg::FIELD_W-1:0]      i_cfg_wdata,
    input  wire [modexp_pkg::FIELD_W-1:0]      i_base,
    input  wire [modexp_pkg::FIELD_W-1:0]      i_exponent,
    input  wire modexp_pkg::t_dp_cmd           i_cmd,
    output modexp_pkg::t_dp_stat               o_stat,
    output logic [modexp_pkg::FIELD_W-1:0]     o_power_mod
);
    import modexp_pkg::*;

    logic [FIELD_W-1:0] r_mod;
    logic [WIDTH-1:0]   r_acc;
    logic [WIDTH-1:0]   r_sq;
    logic [WIDTH-1:0]   r_exp;
    t_op                r_op;
    logic [FIELD_W-1:0] r_out;

    logic [WIDTH-1:0] m;
    logic             mod_small;
    logic [WIDTH-1:0] mm_a;
    logic [WIDTH-1:0] mm_b;
    logic [WIDTH-1:0] mm_res;
    logic             mm_done;

    assign m         = r_mod[WIDTH-1:0];
    assign mod_small = (m < WIDTH'(2));

    always_comb begin
        unique case (i_cmd.op)
            OP_REDUCE: begin
                mm_a = i_base[WIDTH-1:0];
                mm_b = WIDTH'(1);
            end
            OP_MUL: begin
                mm_a = r_acc;
                mm_b = r_sq;
            end
            OP_SQR: begin
                mm_a = r_sq;
                mm_b = r_sq;
            end
            default: begin
                mm_a = r_sq;
                mm_b = r_sq;
            end
        endcase
    end

    modexp_mulmod #(
        .WIDTH (WIDTH)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.start),
        .i_a      (mm_a),
        .i_b      (mm_b),
        .i_m      (m),
        .o_result (mm_res),
        .o_done   (mm_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_RESET;
        end else if (i_cfg_we) begin
            r_mod <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op <= i_cmd.op;
        end
        if (i_cmd.load) begin
            r_exp <= i_exponent[WIDTH-1:0];
            r_acc <= mod_small ? '0 : WIDTH'(1);
        end else begin
            if (i_cmd.shift_exp) begin
                r_exp <= r_exp >> 1;
            end
            if (mm_done) begin
                unique case (r_op)
                    OP_REDUCE: r_sq  <= mm_res;
                    OP_MUL:    r_acc <= mm_res;
                    OP_SQR:    r_sq  <= mm_res;
                    default:   r_sq  <= mm_res;
                endcase
            end
        end
        if (i_cmd.out_load) begin
            r_out <= FIELD_W'(r_acc);
        end
    end

    assign o_stat.mul_done  = mm_done;
    assign o_stat.exp_bit0  = r_exp[0];
    assign o_stat.exp_zero  = (r_exp == '0);
    assign o_stat.mod_small = mod_small;
    assign o_power_mod      = r_out;

endmodule

`default_nettype wire

// ----- rtl/modexp_ctrl.sv -----
// controller: sequences reduce, multiply and square steps and the output word
`default_nettype none

module modexp_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    input  wire modexp_pkg::t_dp_stat i_stat,
    output modexp_pkg::t_dp_cmd  o_cmd
);
    import modexp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_CHK  = 6'b000100,
        S_MUL  = 6'b001000,
        S_SQR  = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '{load: 1'b0, start: 1'b0, op: OP_REDUCE,
                        shift_exp: 1'b0, out_load: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.mod_small) begin
                        n_state = S_FIN;
                    end else begin
                        o_cmd.start = 1'b1;
                        o_cmd.op    = OP_REDUCE;
                        n_state     = S_RED;
                    end
                end
            end
            S_RED: begin
                if (i_stat.mul_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (i_stat.exp_zero) begin
                    n_state = S_FIN;
                end else if (i_stat.exp_bit0) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = OP_MUL;
                    n_state     = S_MUL;
                end else begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = OP_SQR;
                    n_state     = S_SQR;
                end
            end
            S_MUL: begin
                if (i_stat.mul_done) begin
                    o_cmd.start = 1'b1;
                    o_cmd.op    = OP_SQR;
                    n_state     = S_SQR;
                end
            end
            S_SQR: begin
                if (i_stat.mul_done) begin
                    o_cmd.shift_exp = 1'b1;
                    n_state         = S_CHK;
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

// ----- rtl/modular_exponentiation.sv -----
// top level of the modular exponentiation block: power_mod = base^exponent mod modulus
//
// input channel: i_in_valid / o_in_stall carry one word of i_base and i_exponent,
// taken at a clock edge with i_in_valid high and o_in_stall low.
// output channel: o_out_valid / i_out_stall carry one o_power_mod word per input word.
// config: i_cfg_we writes i_cfg_wdata into the modulus register (reset value 2);
// write only while no word is in flight. only the low WIDTH bits of the modulus,
// base and exponent are used. a modulus below 2 gives 0.
// one word is worked at a time by a shared bit-serial modular multiplier. the base
// is reduced first; then, for each exponent bit up to the highest set one, the
// block checks the bit, forms one more product when it is set, then one squaring.
// a finished word sits in the output register; the next input word is taken
// while it waits, and the block holds its own result until the output is free.
// reset (synchronous, active low) drops any word in flight and the output valid.
`default_nettype none

module modular_exponentiation #(
    parameter int WIDTH = modexp_pkg::MODEXP_WIDTH
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_cfg_we,
    input  wire [modexp_pkg::FIELD_W-1:0]     i_cfg_wdata,
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire [modexp_pkg::FIELD_W-1:0]     i_base,
    input  wire [modexp_pkg::FIELD_W-1:0]     i_exponent,
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic [modexp_pkg::FIELD_W-1:0]    o_power_mod
);
    import modexp_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    modexp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    modexp_dp #(
        .WIDTH (WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_power_mod (o_power_mod)
    );

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// self-checking testbench for the modular exponentiation block
`default_nettype none

module testbench;
    import modexp_pkg::*;

    localparam int OPERAND_W  = MODEXP_WIDTH;
    localparam int STUCK_MAX  = 20000;   // cycles with no word moving on either side
    localparam int TAIL_WAIT  = 2400;    // a bit over the worst-case latency
    localparam int PHASES     = 8;
    localparam int PHASE_WORDS = 33;

    typedef enum logic [1:0] {
        FLOW_FREE,
        FLOW_SEND_IDLE,
        FLOW_RECV_STALL,
        FLOW_BOTH
    } t_flow;

    typedef struct packed {
        logic               set_mod;
        logic [FIELD_W-1:0] mod_val;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic               fixed;
        logic [FIELD_W-1:0] value;
    } t_row;

    typedef struct packed {
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
        logic [FIELD_W-1:0] value;
    } t_power_due;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [FIELD_W-1:0] i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic [FIELD_W-1:0] i_base      = '0;
    logic [FIELD_W-1:0] i_exponent  = '0;
    logic               i_out_stall = 1'b0;
    wire                o_in_stall;
    wire                o_out_valid;
    wire [FIELD_W-1:0]  o_power_mod;

    t_flow              flow_mode   = FLOW_FREE;
    logic               row_fixed   = 1'b0;
    logic [FIELD_W-1:0] row_value   = '0;
    logic [FIELD_W-1:0] modulus_now = MOD_RESET;
    int                 error_count = 0;
    int                 stuck_cycles = 0;
    t_power_due         power_due[$];
    t_row               directed_rows[23];

    modular_exponentiation i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_base      (i_base),
        .i_exponent  (i_exponent),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_power_mod (o_power_mod)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // right-to-left square and multiply on the low OPERAND_W bits
    function automatic logic [FIELD_W-1:0] power_mod_of(input logic [FIELD_W-1:0] b,
                                                        input logic [FIELD_W-1:0] e,
                                                        input logic [FIELD_W-1:0] m);
        logic [63:0] mask;
        logic [63:0] b64;
        logic [63:0] e64;
        logic [63:0] m64;
        logic [63:0] acc;
        logic [63:0] sq;
        mask = (64'd1 << OPERAND_W) - 64'd1;
        b64  = {32'd0, b} & mask;
        e64  = {32'd0, e} & mask;
        m64  = {32'd0, m} & mask;
        if (m64 < 64'd2)
            return '0;
        acc = 64'd1;
        sq  = b64 % m64;
        for (int k = 0; k < OPERAND_W; k++) begin
            if (e64[k])
                acc = (acc * sq) % m64;
            sq = (sq * sq) % m64;
        end
        return acc[FIELD_W-1:0];
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        $display("testbench: mismatch: %s", msg);
    endtask

    // both channels and the register write, seen at the rising edge
    always @(posedge i_clk) begin
        t_power_due due;
        t_power_due got_due;
        logic moved;
        moved = 1'b0;
        if (!i_rst_n) begin
            modulus_now = MOD_RESET;
        end else begin
            if (i_cfg_we)
                modulus_now = i_cfg_wdata;
            if (i_in_valid && o_in_stall === 1'b0) begin
                due.base     = i_base;
                due.exponent = i_exponent;
                due.modulus  = modulus_now;
                due.value    = row_fixed ? row_value
                                         : power_mod_of(i_base, i_exponent, modulus_now);
                power_due.push_back(due);
                moved = 1'b1;
            end
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                moved = 1'b1;
                if (power_due.size() == 0) begin
                    report_mismatch($sformatf("word %h with nothing outstanding", o_power_mod));
                end else begin
                    got_due = power_due.pop_front();
                    if (o_power_mod !== got_due.value)
                        report_mismatch($sformatf("%h^%h mod %h: got %h, want %h",
                            got_due.base, got_due.exponent, got_due.modulus,
                            o_power_mod, got_due.value));
                end
            end
        end
        stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end

    always @(negedge i_clk) begin
        case (flow_mode)
            FLOW_RECV_STALL: i_out_stall = ($urandom_range(0, 99) < 83);
            FLOW_BOTH:       i_out_stall = ($urandom_range(0, 99) < 19);
            default:         i_out_stall = 1'b0;
        endcase
    end

    task automatic send_word(input logic [FIELD_W-1:0] b, input logic [FIELD_W-1:0] e,
                             input logic fixed, input logic [FIELD_W-1:0] value);
        int idle_pct;
        idle_pct = (flow_mode == FLOW_SEND_IDLE) ? 83 : (flow_mode == FLOW_BOTH) ? 19 : 0;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_base     = b;
        i_exponent = e;
        row_fixed  = fixed;
        row_value  = value;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (power_due.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_modulus(input logic [FIELD_W-1:0] value);
        drain_results();
        repeat (4) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    initial begin
        wait (stuck_cycles >= STUCK_MAX);
        $display("testbench: done, errors");
        $finish;
    end

    initial begin
        logic [FIELD_W-1:0] phase_mod;
        logic [FIELD_W-1:0] b;
        logic [FIELD_W-1:0] e;

        directed_rows = '{
            // modulus still at its reset value
            '{1'b0, 32'd0,          32'd3,          32'd1,          1'b1, 32'd1},
            '{1'b0, 32'd0,          32'd0,          32'd0,          1'b1, 32'd1},
            '{1'b0, 32'd0,          32'hffff_ffff,  32'hffff_ffff,  1'b1, 32'd1},
            '{1'b0, 32'd0,          32'd2,          32'd5,          1'b1, 32'd0},
            // zero modulus gives zero, even for a zero exponent
            '{1'b1, 32'd0,          32'd5,          32'd7,          1'b1, 32'd0},
            '{1'b0, 32'd0,          32'd0,          32'd0,          1'b1, 32'd0},
            // modulus of one
            '{1'b1, 32'd1,          32'hffff_ffff,  32'hffff_ffff,  1'b1, 32'd0},
            '{1'b0, 32'd0,          32'd0,          32'd0,          1'b1, 32'd0},
            // all-ones modulus: base equal to it reduces to zero
            '{1'b1, 32'hffff_ffff,  32'd0,          32'd0,          1'b1, 32'd1},
            '{1'b0, 32'd0,          32'hffff_ffff,  32'd1,          1'b1, 32'd0},
            '{1'b0, 32'd0,          32'hffff_fffe,  32'd2,          1'b1, 32'd1},
            '{1'b0, 32'd0,          32'hffff_fffe,  32'hffff_ffff,  1'b1, 32'hffff_fffe},
            '{1'b0, 32'd0,          32'h1234_5678,  32'hffff_ffff,  1'b0, 32'd0},
            '{1'b0, 32'd0,          32'h8000_0000,  32'h8000_0000,  1'b0, 32'd0},
            // small prime, one base above the modulus
            '{1'b1, 32'd97,         32'd3,          32'd0,          1'b1, 32'd1},
            '{1'b0, 32'd0,          32'd200,        32'd1,          1'b1, 32'd6},
            '{1'b0, 32'd0,          32'd5,          32'd96,         1'b0, 32'd0},
            '{1'b0, 32'd0,          32'd0,          32'd5,          1'b1, 32'd0},
            // largest 32-bit prime, then a power-of-two modulus
            '{1'b1, 32'hffff_fffb,  32'd2,          32'hffff_fffa,  1'b0, 32'd0},
            '{1'b0, 32'd0,          32'hffff_ffff,  32'hffff_ffff,  1'b0, 32'd0},
            '{1'b0, 32'd0,          32'hdead_beef,  32'h5555_5555,  1'b0, 32'd0},
            '{1'b1, 32'h8000_0000,  32'd3,          32'haaaa_aaaa,  1'b0, 32'd0},
            '{1'b0, 32'd0,          32'h7fff_ffff,  32'd3,          1'b0, 32'd0}
        };

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].set_mod)
                write_modulus(directed_rows[r].mod_val);
            send_word(directed_rows[r].base, directed_rows[r].exponent,
                      directed_rows[r].fixed, directed_rows[r].value);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       phase_mod = 32'hffff_fffb;
                1:       phase_mod = $urandom | 32'h8000_0000;
                2:       phase_mod = $urandom_range(2, 255);
                3:       phase_mod = 32'hffff_ffff;
                4:       phase_mod = 32'd2;
                5:       phase_mod = $urandom;
                6:       phase_mod = 32'h8000_0000;
                default: phase_mod = $urandom_range(2, 65535);
            endcase
            write_modulus(phase_mod);
            flow_mode = t_flow'(p % 4);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                case ($urandom_range(0, 3))
                    0:       b = $urandom_range(0, 3);
                    1:       b = phase_mod + $urandom_range(0, 2) - 1;
                    default: b = $urandom;
                endcase
                // short exponents keep the run time down
                case ($urandom_range(0, 3))
                    0:       e = $urandom;
                    1:       e = $urandom_range(0, 3);
                    default: e = $urandom >> $urandom_range(1, 31);
                endcase
                send_word(b, e, 1'b0, '0);
            end
        end

        drain_results();
        flow_mode = FLOW_FREE;
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (error_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
